/* sv/rmsn_pkg.sv */
// Shared types and constants of the RMS normalizer.
package rmsn_pkg;

  localparam int DATA_BITS = 16;
  localparam int SUM_W     = 48;
  localparam int INV_W     = 32;
  localparam int DIV_W     = 64;
  localparam int REM_W     = 35;
  localparam int EPS_W     = 16;

  typedef logic signed [DATA_BITS-1:0] data_t;
  typedef logic [1:0]                  status_t;

  // Request kinds
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EMIT = 1'b1;

  // Result status codes
  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_OVERFLOW = 2'd1;
  localparam status_t ST_EMPTY    = 2'd2;

  // Register map (word index from paddr[2])
  localparam logic REG_EPSILON = 1'b0;

  localparam logic [EPS_W-1:0] EPS_RESET = 16'd1;

endpackage

/* sv/rms_normalizer_unit.sv */
// RMS normalizer top level: element memory, shared divider and square root, emit datapath.
// Loads store one Q8.8 element each in the element memory (a load beyond MAX_LEN elements
// gets an overflow result instead). The load marked last then runs the mean-square division,
// the reciprocal division and the square root on one shared shift-subtract unit; the last two
// are skipped when the mean square plus epsilon is zero. An emit reads the memory through a
// registered read, multiplies in two registered stages and rounds, then places the result in
// the output register; an error result goes to the output register directly.
// One request is in flight at a time; a result waits in the output register until taken.
module rms_normalizer_unit
  import rmsn_pkg::*;
#(
  parameter int MAX_LEN = 2048
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [15:0] x_value, [31:16] gain_value
  input  logic        in_tlast,   // last_in
  input  logic        in_tuser,   // op
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] y_value
  output logic        out_tlast,  // last_out
  output logic [1:0]  out_tuser,  // status
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int CNT_W = $clog2(MAX_LEN + 1);
  localparam int AW    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SQR  = 4'd1;
  localparam logic [3:0] S_ACC  = 4'd2;
  localparam logic [3:0] S_DIV1 = 4'd3;
  localparam logic [3:0] S_DIV2 = 4'd4;
  localparam logic [3:0] S_SQRT = 4'd5;
  localparam logic [3:0] S_MUL1 = 4'd6;
  localparam logic [3:0] S_MUL2 = 4'd7;
  localparam logic [3:0] S_RND  = 4'd8;
  localparam logic [3:0] S_PUSH = 4'd9;

  logic [3:0]       state_r, state_nxt;
  logic [EPS_W-1:0] eps_r;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [INV_W-1:0] inv_r, inv_nxt;
  logic [CNT_W-1:0] rp_r, rp_nxt;
  logic             rdy_r, rdy_nxt;
  data_t            x_r, x_nxt;
  data_t            g_r, g_nxt;
  logic             fin_r, fin_nxt;
  logic [31:0]      sq_r, sq_nxt;
  logic [DIV_W-1:0] dvd_r, dvd_nxt;
  logic [31:0]      dvs_r, dvs_nxt;
  logic [REM_W-1:0] rem_r, rem_nxt;
  logic [DIV_W-1:0] quo_r, quo_nxt;
  logic [31:0]      root_r, root_nxt;
  logic [5:0]       step_r, step_nxt;
  logic             neg_r, neg_nxt;
  logic [31:0]      p1_r, p1_nxt;
  logic [63:0]      p2_r, p2_nxt;
  data_t            res_y_r, res_y_nxt;
  logic             res_last_r, res_last_nxt;
  status_t          res_st_r, res_st_nxt;
  logic             o_valid_r, o_valid_nxt;
  data_t            o_y_r, o_y_nxt;
  logic             o_last_r, o_last_nxt;
  status_t          o_st_r, o_st_nxt;

  // Element memory
  data_t            mem [MAX_LEN];
  data_t            rd_data_r;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;

  logic             in_acc;
  logic             cfg_wr;
  logic [CNT_W-1:0] eff_cnt;
  logic [32:0]      div_sh;
  logic             div_ge;
  logic [REM_W-1:0] sqr_sh, sqr_trial;
  logic             sqr_ge;
  logic [31:0]      m_val;
  logic [15:0]      ax, ag;
  logic [63:0]      q_val;

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = (cfg_paddr[2] == REG_EPSILON) ? {16'd0, eps_r} : 32'd0;
  assign out_tvalid = o_valid_r;
  assign out_tdata  = o_y_r;
  assign out_tlast  = o_last_r;
  assign out_tuser  = o_st_r;

  // A load after a finished vector starts from an empty vector
  assign eff_cnt = rdy_r ? '0 : cnt_r;
  assign wr_en   = in_acc && (in_tuser == OP_LOAD) && (eff_cnt < CNT_W'(MAX_LEN));
  assign wr_addr = eff_cnt[AW-1:0];

  // Shift-subtract divider step
  assign div_sh = {rem_r[31:0], dvd_r[DIV_W-1]};
  assign div_ge = div_sh >= {1'b0, dvs_r};

  // Digit-by-digit square root step
  assign sqr_sh    = {rem_r[REM_W-3:0], dvd_r[DIV_W-1:DIV_W-2]};
  assign sqr_trial = {1'b0, root_r, 2'b01};
  assign sqr_ge    = sqr_sh >= sqr_trial;

  // Mean square from the final quotient bit of this step, plus epsilon
  assign m_val = {quo_r[30:0], div_ge} + {16'd0, eps_r};
  assign ax    = rd_data_r[DATA_BITS-1] ? 16'(-rd_data_r) : 16'(rd_data_r);
  assign ag    = g_r[DATA_BITS-1] ? 16'(-g_r) : 16'(g_r);
  assign q_val = ((p2_r >> 1) + 64'h2000_0000) >> 30;

  always_comb begin
    state_nxt    = state_r;
    sum_nxt      = sum_r;
    cnt_nxt      = cnt_r;
    inv_nxt      = inv_r;
    rp_nxt       = rp_r;
    rdy_nxt      = rdy_r;
    x_nxt        = x_r;
    g_nxt        = g_r;
    fin_nxt      = fin_r;
    sq_nxt       = sq_r;
    dvd_nxt      = dvd_r;
    dvs_nxt      = dvs_r;
    rem_nxt      = rem_r;
    quo_nxt      = quo_r;
    root_nxt     = root_r;
    step_nxt     = step_r;
    neg_nxt      = neg_r;
    p1_nxt       = p1_r;
    p2_nxt       = p2_r;
    res_y_nxt    = res_y_r;
    res_last_nxt = res_last_r;
    res_st_nxt   = res_st_r;
    o_valid_nxt  = o_valid_r;
    o_y_nxt      = o_y_r;
    o_last_nxt   = o_last_r;
    o_st_nxt     = o_st_r;

    // Drop the output once taken
    if (o_valid_r && out_tready) begin
      o_valid_nxt = 1'b0;
    end

    unique case (state_r) inside
      S_IDLE: begin
        if (in_acc) begin
          x_nxt   = data_t'(in_tdata[15:0]);
          g_nxt   = data_t'(in_tdata[31:16]);
          fin_nxt = in_tlast;
          if (in_tuser == OP_LOAD) begin
            if (rdy_r) begin
              sum_nxt = '0;
              rp_nxt  = '0;
              rdy_nxt = 1'b0;
            end
            cnt_nxt = eff_cnt;
            if (wr_en) begin
              cnt_nxt   = eff_cnt + 1'b1;
              state_nxt = S_SQR;
            end else begin
              res_y_nxt    = '0;
              res_last_nxt = 1'b0;
              res_st_nxt   = ST_OVERFLOW;
              state_nxt    = S_PUSH;
            end
          end else if (!rdy_r || rp_r >= cnt_r) begin
            fin_nxt      = 1'b0;
            res_y_nxt    = '0;
            res_last_nxt = 1'b0;
            res_st_nxt   = ST_EMPTY;
            state_nxt    = S_PUSH;
          end else begin
            // Memory read of rp_r is in flight
            fin_nxt      = 1'b0;
            res_last_nxt = (rp_r + 1'b1 == cnt_r);
            rp_nxt       = rp_r + 1'b1;
            if (rp_r + 1'b1 == cnt_r) begin
              sum_nxt = '0;
              cnt_nxt = '0;
              rp_nxt  = '0;
              rdy_nxt = 1'b0;
            end
            state_nxt = S_MUL1;
          end
        end
      end
      S_SQR: begin
        sq_nxt    = 32'(x_r) * 32'(x_r);
        state_nxt = S_ACC;
      end
      S_ACC: begin
        sum_nxt = sum_r + {16'd0, sq_r};
        if (fin_r) begin
          dvd_nxt   = {16'd0, sum_r + {16'd0, sq_r}};
          dvs_nxt   = {{(32-CNT_W){1'b0}}, cnt_r};
          rem_nxt   = '0;
          step_nxt  = '0;
          state_nxt = S_DIV1;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_DIV1, S_DIV2: begin
        rem_nxt  = REM_W'(div_ge ? div_sh - {1'b0, dvs_r} : div_sh);
        quo_nxt  = {quo_r[DIV_W-2:0], div_ge};
        dvd_nxt  = dvd_r << 1;
        step_nxt = step_r + 1'b1;
        if (step_r == 6'd63) begin
          rem_nxt  = '0;
          step_nxt = '0;
          if (state_r == S_DIV1) begin
            // Mean square plus epsilon, then 2^62 / m
            if (m_val == '0) begin
              inv_nxt   = '1;
              rp_nxt    = '0;
              rdy_nxt   = 1'b1;
              state_nxt = S_IDLE;
            end else begin
              dvd_nxt   = 64'h4000_0000_0000_0000;
              dvs_nxt   = m_val;
              state_nxt = S_DIV2;
            end
          end else begin
            dvd_nxt   = {quo_r[DIV_W-2:0], div_ge};
            root_nxt  = '0;
            state_nxt = S_SQRT;
          end
        end
      end
      S_SQRT: begin
        rem_nxt  = sqr_ge ? sqr_sh - sqr_trial : sqr_sh;
        root_nxt = {root_r[30:0], sqr_ge};
        dvd_nxt  = dvd_r << 2;
        step_nxt = step_r + 1'b1;
        if (step_r == 6'd31) begin
          inv_nxt   = {root_r[30:0], sqr_ge};
          rp_nxt    = '0;
          rdy_nxt   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_MUL1: begin
        p1_nxt    = ax * ag;
        neg_nxt   = rd_data_r[DATA_BITS-1] ^ g_r[DATA_BITS-1];
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        p2_nxt    = {32'd0, p1_r} * {32'd0, inv_r};
        state_nxt = S_RND;
      end
      S_RND: begin
        // Round half away from zero, saturate to Q8.8
        if (q_val >= 64'd32768) begin
          res_y_nxt = neg_r ? data_t'(16'h8000) : data_t'(16'h7FFF);
        end else begin
          res_y_nxt = neg_r ? data_t'(-q_val[15:0]) : data_t'(q_val[15:0]);
        end
        res_st_nxt = ST_OK;
        state_nxt  = S_PUSH;
      end
      S_PUSH: begin
        if (!o_valid_r || out_tready) begin
          o_valid_nxt = 1'b1;
          o_y_nxt     = res_y_r;
          o_last_nxt  = res_last_r;
          o_st_nxt    = res_st_r;
          if (fin_r) begin
            dvd_nxt   = {16'd0, sum_r};
            dvs_nxt   = {{(32-CNT_W){1'b0}}, cnt_r};
            rem_nxt   = '0;
            step_nxt  = '0;
            state_nxt = S_DIV1;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      eps_r     <= EPS_RESET;
      sum_r     <= '0;
      cnt_r     <= '0;
      inv_r     <= '0;
      rp_r      <= '0;
      rdy_r     <= 1'b0;
      fin_r     <= 1'b0;
      o_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      sum_r     <= sum_nxt;
      cnt_r     <= cnt_nxt;
      inv_r     <= inv_nxt;
      rp_r      <= rp_nxt;
      rdy_r     <= rdy_nxt;
      fin_r     <= fin_nxt;
      o_valid_r <= o_valid_nxt;
      if (cfg_wr && cfg_paddr[2] == REG_EPSILON) begin
        eps_r <= cfg_pwdata[EPS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    x_r        <= x_nxt;
    g_r        <= g_nxt;
    sq_r       <= sq_nxt;
    dvd_r      <= dvd_nxt;
    dvs_r      <= dvs_nxt;
    rem_r      <= rem_nxt;
    quo_r      <= quo_nxt;
    root_r     <= root_nxt;
    step_r     <= step_nxt;
    neg_r      <= neg_nxt;
    p1_r       <= p1_nxt;
    p2_r       <= p2_nxt;
    res_y_r    <= res_y_nxt;
    res_last_r <= res_last_nxt;
    res_st_r   <= res_st_nxt;
    o_y_r      <= o_y_nxt;
    o_last_r   <= o_last_nxt;
    o_st_r     <= o_st_nxt;
  end

  // Element memory: write on load, registered read at the read pointer
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= data_t'(in_tdata[15:0]);
    end
    rd_data_r <= mem[rp_r[AW-1:0]];
  end

  // Error results carry a zero value
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ST_OK |-> out_tdata == '0)
    else $error("error result with nonzero value");

  // Last mark only on good results
  a_last_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser == ST_OK)
    else $error("last mark on error result");

  // A finished vector is never empty
  a_rdy_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    rdy_r |-> cnt_r != '0 && rp_r < cnt_r)
    else $error("ready vector with bad count or pointer");

  // Requests only enter while idle
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |=> !(in_tvalid && in_tready) || $past(state_nxt) == S_IDLE)
    else $error("request accepted while busy");

endmodule
